@@ design/tmg_pkg.sv @@
// Package for the tonemap / gamma / pack pipeline: word types, curve constants,
// stage count and the gamma table builder. No dependencies.
`timescale 1ns / 1ps

package tmg_pkg;

  // defaults for the gamma curve
  localparam int unsigned GammaTenthsDefault    = 22;
  localparam int unsigned GammaTableBitsDefault = 10;

  // largest table: 2^12 + 1 entries of one byte
  localparam int unsigned LutEntriesMax = 4097;
  localparam int unsigned LutBitsMax    = LutEntriesMax * 8;

  // widths of the fixed-point curve terms
  localparam int unsigned RadW  = 24;
  localparam int unsigned SqW   = 48;
  localparam int unsigned PolyW = 56;
  localparam int unsigned RemW  = 57;

  // curve coefficients, scaled to integers
  localparam logic [PolyW-1:0] NumSq  = 56'd251;
  localparam logic [PolyW-1:0] NumLin = 56'd196608;
  localparam logic [PolyW-1:0] DenSq  = 56'd243;
  localparam logic [PolyW-1:0] DenLin = 56'd3866624;
  localparam logic [PolyW-1:0] DenK   = 56'd14 << 32;

  // config register indexes
  localparam logic RegWidth  = 1'b0;
  localparam logic RegHeight = 1'b1;

  localparam int unsigned CfgW = 13;

  typedef struct packed {
    logic [23:0] red_linear;
    logic [23:0] green_linear;
    logic [23:0] blue_linear;
    logic [11:0] pixel_x;
    logic [11:0] pixel_y;
  } in_word_t;

  typedef struct packed {
    logic [25:0] byte_offset;
    logic [7:0]  red_byte;
    logic [7:0]  green_byte;
    logic [7:0]  blue_byte;
  } out_word_t;

  // pipeline depth: square, polynomial, up to two quotient bits per stage, table
  function automatic int unsigned tmg_stages(input int unsigned bits);
    return 3 + (bits + 1) / 2;
  endfunction

  // table[i] = largest b with b^g * 2^(10*bits) <= i^10 * 255^g
  function automatic logic [LutBitsMax-1:0] build_gamma_lut(input int unsigned g,
                                                            input int unsigned bits);
    logic [LutBitsMax-1:0] lut;
    logic [399:0] rhs;
    logic [399:0] lhs;
    int unsigned b;
    logic stop;
    lut = '0;
    b = 0;
    for (int unsigned i = 0; i <= (1 << bits); i++) begin
      rhs = 400'd1;
      for (int k = 0; k < 10; k++) rhs = rhs * 400'(i);
      for (int unsigned k = 0; k < g; k++) rhs = rhs * 400'd255;
      stop = 1'b0;
      while (b < 255 && !stop) begin
        lhs = 400'd1;
        for (int unsigned k = 0; k < g; k++) lhs = lhs * 400'(b + 1);
        lhs = lhs << (10 * bits);
        if (lhs <= rhs) b = b + 1;
        else stop = 1'b1;
      end
      lut[i*8 +: 8] = 8'(b);
    end
    return lut;
  endfunction

endpackage

@@ design/tonemap_gamma_pixel_pack.sv @@
// Top level: bounds check, byte offset, stall control, three channel pipes.
// Depends on tmg_pkg and tmg_channel.
`timescale 1ns / 1ps
//
//  port group   dir  handshake              word
//  in_*         in   in_valid / in_ready    in_word_t  (RGB Q8.16, x, y)
//  out_*        out  out_valid / out_ready  out_word_t (offset, RGB bytes)
//  cfg_*        in   cfg_we                 cfg_addr selects width/height
//
//  One pixel per clock while out_ready is high, through 3 + ceil(GAMMA_TABLE_BITS/2)
//  register stages (8 at defaults), set by the two-bit-per-stage division of the curve.
//  Pixels outside the image are taken and dropped at the first stage.
//  Stalls back up stage by stage; an empty stage always takes a new word.
//  Reset clears valid bits and sets width and height to 1024.

module tonemap_gamma_pixel_pack import tmg_pkg::*; #(
  parameter int unsigned GAMMA_TENTHS     = GammaTenthsDefault,
  parameter int unsigned GAMMA_TABLE_BITS = GammaTableBitsDefault
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  in_word_t        in_word,
  output logic            out_valid,
  input  logic            out_ready,
  output out_word_t       out_word,
  input  logic            cfg_we,
  input  logic            cfg_addr,
  input  logic [CfgW-1:0] cfg_data
);

  localparam int unsigned NStages = tmg_stages(GAMMA_TABLE_BITS);

  // config registers
  logic [CfgW-1:0] image_width, image_height;
  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= CfgW'(1024);
      image_height <= CfgW'(1024);
    end else if (cfg_we) begin
      unique case (cfg_addr)
        RegWidth:  image_width  <= cfg_data;
        RegHeight: image_height <= cfg_data;
        default:   ;
      endcase
    end
  end

  // stage control: a stage loads when empty or when its successor loads
  logic [NStages-1:0] vld;
  logic [NStages:0]   load;
  always_comb begin
    load[NStages] = out_ready;
    for (int s = NStages - 1; s >= 0; s--) begin
      load[s] = !vld[s] || load[s+1];
    end
  end
  assign in_ready = load[0];

  logic accept, in_bounds;
  assign accept    = in_valid && in_ready;
  assign in_bounds = ({1'b0, in_word.pixel_x} < image_width) &&
                     ({1'b0, in_word.pixel_y} < image_height);

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (load[0]) vld[0] <= accept && in_bounds;
      for (int s = 1; s < NStages; s++) begin
        if (load[s]) vld[s] <= vld[s-1];
      end
    end
  end

  // byte offset, carried alongside the channel pipes
  logic [25:0] pix_index;
  logic [25:0] offset_q [NStages];
  assign pix_index = 26'(in_word.pixel_y) * 26'(image_width) + 26'(in_word.pixel_x);

  always_ff @(posedge clk) begin
    if (load[0]) offset_q[0] <= {pix_index[23:0], 2'b00};
    for (int s = 1; s < NStages; s++) begin
      if (load[s]) offset_q[s] <= offset_q[s-1];
    end
  end

  // channel pipes
  logic [7:0] red_b, green_b, blue_b;

  tmg_channel #(.GAMMA_TENTHS(GAMMA_TENTHS), .GAMMA_TABLE_BITS(GAMMA_TABLE_BITS)) u_red (
    .clk(clk), .load(load[NStages-1:0]), .x_in(in_word.red_linear), .byte_out(red_b)
  );
  tmg_channel #(.GAMMA_TENTHS(GAMMA_TENTHS), .GAMMA_TABLE_BITS(GAMMA_TABLE_BITS)) u_green (
    .clk(clk), .load(load[NStages-1:0]), .x_in(in_word.green_linear), .byte_out(green_b)
  );
  tmg_channel #(.GAMMA_TENTHS(GAMMA_TENTHS), .GAMMA_TABLE_BITS(GAMMA_TABLE_BITS)) u_blue (
    .clk(clk), .load(load[NStages-1:0]), .x_in(in_word.blue_linear), .byte_out(blue_b)
  );

  assign out_valid            = vld[NStages-1];
  assign out_word.byte_offset = offset_q[NStages-1];
  assign out_word.red_byte    = red_b;
  assign out_word.green_byte  = green_b;
  assign out_word.blue_byte   = blue_b;

`ifndef SYNTHESIS
  // a pixel outside the image never enters the pipe
  a_drop_oob: assert property (@(posedge clk) disable iff (rst)
    accept && !in_bounds |=> !vld[0])
    else $error("out-of-bounds pixel entered pipe");

  // nothing valid right after reset
  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> vld == '0)
    else $error("valid bit set after reset");

  // a stalled first stage keeps its word
  a_hold_first: assert property (@(posedge clk) disable iff (rst)
    vld[0] && !load[1] |=> vld[0] && $stable(offset_q[0]))
    else $error("stalled first stage lost its word");

  // a full pipe under stall accepts nothing
  a_full_stall: assert property (@(posedge clk) disable iff (rst)
    (&vld) && !out_ready |-> !in_ready)
    else $error("input taken while pipe full and stalled");
`endif

endmodule

@@ design/tmg_channel.sv @@
// One color channel: filmic curve, pipelined restoring division to a table
// index, gamma table. Depends on tmg_pkg; stage enables come from the top level.
`timescale 1ns / 1ps

module tmg_channel import tmg_pkg::*; #(
  parameter int unsigned GAMMA_TENTHS     = GammaTenthsDefault,
  parameter int unsigned GAMMA_TABLE_BITS = GammaTableBitsDefault,
  localparam int unsigned NStages = tmg_stages(GAMMA_TABLE_BITS)
) (
  input  logic               clk,
  input  logic [NStages-1:0] load,
  input  logic [RadW-1:0]    x_in,
  output logic [7:0]         byte_out
);

  localparam int unsigned B       = GAMMA_TABLE_BITS;
  localparam int unsigned DivSt   = (B + 1) / 2;
  localparam int unsigned LastSt  = NStages - 1;
  localparam logic [LutBitsMax-1:0] GammaLut = build_gamma_lut(GAMMA_TENTHS, B);

  // stage 0: square
  logic [RadW-1:0] x0;
  logic [SqW-1:0]  xx0;
  always_ff @(posedge clk) begin
    if (load[0]) begin
      x0  <= x_in;
      xx0 <= x_in * x_in;
    end
  end

  // stage 1: numerator and denominator polynomials
  logic [PolyW-1:0] num1, den1;
  always_ff @(posedge clk) begin
    if (load[1]) begin
      num1 <= PolyW'(xx0) * NumSq + PolyW'(x0) * NumLin;
      den1 <= PolyW'(xx0) * DenSq + PolyW'(x0) * DenLin + DenK;
    end
  end

  // division stages: two quotient bits each, one in the last when GAMMA_TABLE_BITS is odd
  logic [RemW-1:0]  rem_q [DivSt];
  logic [PolyW-1:0] den_q [DivSt];
  logic [B-1:0]     idx_q [DivSt];
  logic             sat_q [DivSt];

  for (genvar d = 0; d < DivSt; d++) begin : g_div
    logic [RemW-1:0]  rem_in;
    logic [B-1:0]     idx_in;
    logic [RemW-1:0]  rem_next;
    logic [B-1:0]     idx_next;
    logic             sat_next;
    logic [PolyW-1:0] den_in;

    // first stage starts from the polynomials, later ones from the stage before
    if (d == 0) begin : g_head
      assign den_in   = den1;
      assign sat_next = (num1 >= den1);
      assign rem_in   = RemW'(num1);
      assign idx_in   = '0;
    end else begin : g_body
      assign den_in   = den_q[d-1];
      assign sat_next = sat_q[d-1];
      assign rem_in   = rem_q[d-1];
      assign idx_in   = idx_q[d-1];
    end

    always_comb begin
      logic [RemW-1:0] r;
      logic [B-1:0]    q;
      r = rem_in;
      q = idx_in;
      for (int j = 0; j < 2; j++) begin
        if (d * 2 + j < B) begin
          r = r << 1;
          q = q << 1;
          if (r >= RemW'(den_in)) begin
            r    = r - RemW'(den_in);
            q[0] = 1'b1;
          end
        end
      end
      rem_next = r;
      idx_next = q;
    end

    always_ff @(posedge clk) begin
      if (load[2 + d]) begin
        rem_q[d] <= rem_next;
        den_q[d] <= den_in;
        idx_q[d] <= idx_next;
        sat_q[d] <= sat_next;
      end
    end
  end

  // last stage: gamma table
  logic [B:0] lut_idx;
  assign lut_idx = sat_q[DivSt-1] ? (B+1)'(1) << B : {1'b0, idx_q[DivSt-1]};

  always_ff @(posedge clk) begin
    if (load[LastSt]) begin
      byte_out <= GammaLut[{lut_idx, 3'b000} +: 8];
    end
  end

endmodule
